// File: hw/rtl/mwf_pkg.sv
`timescale 1ns / 1ps
// shared types, register codes and helpers of the rgb window maximum filter
// no dependencies
package mwf_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // one window column: channel maxima over the rows and the pixel of the middle row
  typedef struct packed {
    rgb_t colmax;
    rgb_t mid;
  } col_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } reg_idx_t;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [10:0] HEIGHT_RST = 11'd480;
  localparam logic [1:0]  RADIUS_RST = 2'd1;

  function automatic rgb_t rgb_max(rgb_t a, rgb_t b);
    rgb_t m;
    m.red   = (a.red   > b.red)   ? a.red   : b.red;
    m.green = (a.green > b.green) ? a.green : b.green;
    m.blue  = (a.blue  > b.blue)  ? a.blue  : b.blue;
    return m;
  endfunction

endpackage

// File: hw/rtl/mwf_if.sv
`timescale 1ns / 1ps
// valid/ready stream interfaces for pixel items and filter results
// no dependencies
interface mwf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source(output valid, command, in_red, in_green, in_blue, input ready);
  modport sink(input valid, command, in_red, in_green, in_blue, output ready);
endinterface

interface mwf_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] out_x;
  logic [9:0] out_y;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source(output valid, out_x, out_y, out_red, out_green, out_blue, frame_end,
                 input ready);
  modport sink(input valid, out_x, out_y, out_red, out_green, out_blue, frame_end,
               output ready);
endinterface

// File: hw/rtl/rgb_window_maximum_filter.sv
`timescale 1ns / 1ps
// rgb window maximum filter top level: counters, line banks, cell chain, output stage
// depends on mwf_pkg, mwf_if, mwf_line_bank, mwf_cell
//
// pixel_in carries items in raster order: command pixel writes one pixel, command flush
// drains one pending result once the whole frame is in. pixel_out gives one result per
// emitting transaction: position, per-channel window maximum (original pixel at the
// border) and frame_end on the last position of the frame.
// frame_width, frame_height and radius are written through the apb port (addresses 0, 4,
// 8); the user writes them only while the block is idle (the block does not enforce it); a
// write to one of them restarts the frame. a transaction's result passes the stage 1,
// stage 2 and output registers; results trail the input by radius lines plus radius pixels.
// throughput: one item per cycle unless the receiver stalls; the line banks are read once
// per item at one column and the window advances by one column per item.
// frames of fewer than radius lines plus radius pixels drain from the banks pixel by pixel.
// reset restores the register defaults (640 x 480, radius 1) and clears the counters
// and the pipeline; no clearing pass is needed.
// when the receiver stalls, results queue in the three pipeline stages and pixel_in
// keeps accepting until all of them are full.
module rgb_window_maximum_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic        clk,
  input  logic        rst,
  mwf_in_if.sink      pixel_in,
  mwf_out_if.source   pixel_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mwf_pkg::*;

  localparam int LINES = 2 * MAX_RADIUS + 1;
  localparam int SW    = $clog2(LINES);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int RY    = $clog2(MAX_HEIGHT);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  // configuration
  logic [10:0] cfg_width;
  logic [10:0] cfg_height;
  logic [1:0]  cfg_radius;
  logic        cfg_wr;
  logic        cfg_hit;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = cfg_wr && (paddr[3:2] != 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= WIDTH_RST;
      cfg_height <= HEIGHT_RST;
      cfg_radius <= RADIUS_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_WIDTH:  cfg_width  <= pwdata[10:0];
        REG_HEIGHT: cfg_height <= pwdata[10:0];
        REG_RADIUS: cfg_radius <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_WIDTH:  prdata = 32'(cfg_width);
      REG_HEIGHT: prdata = 32'(cfg_height);
      REG_RADIUS: prdata = 32'(cfg_radius);
      default:    prdata = 32'd0;
    endcase
  end

  // effective frame geometry
  logic [XW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [1:0]    r_eff;
  logic [PW-1:0] delay;

  always_comb begin
    if (cfg_width == 11'd0) w_eff = XW'(1);
    else if (32'(cfg_width) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(cfg_width);
    if (cfg_height == 11'd0) h_eff = HW'(1);
    else if (32'(cfg_height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(cfg_height);
    if (32'(cfg_radius) > MAX_RADIUS) r_eff = 2'(MAX_RADIUS);
    else r_eff = cfg_radius;
  end

  assign delay = PW'(w_eff) * PW'(r_eff) + PW'(r_eff);

  // input and output side counters
  logic [CW-1:0] p_col;
  logic [YW-1:0] p_line;
  logic [SW-1:0] p_slot;
  logic [PW-1:0] pos;
  logic          done;
  logic [CW-1:0] ox;
  logic [RY-1:0] oy;
  logic [SW-1:0] o_slot;

  logic acc, is_pix, step, emit, col_last, out_last, out_col_last, interior, direct;
  rgb_t in_pix;

  logic can1, can2, can3;

  assign acc          = pixel_in.valid && pixel_in.ready;
  assign is_pix       = (pixel_in.command == CMD_PIXEL);
  assign step         = acc && (is_pix ? !done : done);
  assign emit         = acc && (is_pix ? (!done && pos >= delay) : done);
  // whole frame shorter than the delay: flushes read their pixel straight from the banks
  assign direct       = done && (pos < delay);
  assign col_last     = (XW'(p_col) + XW'(1)) == w_eff;
  assign out_col_last = (XW'(ox) + XW'(1)) == w_eff;
  assign out_last     = out_col_last && ((HW'(oy) + HW'(1)) == h_eff);
  assign interior     = (XW'(ox) >= XW'(r_eff)) && (HW'(oy) >= HW'(r_eff)) &&
                        ((XW+1)'(ox) + (XW+1)'(r_eff) < (XW+1)'(w_eff)) &&
                        ((HW+1)'(oy) + (HW+1)'(r_eff) < (HW+1)'(h_eff));
  assign in_pix       = '{red: pixel_in.in_red, green: pixel_in.in_green,
                          blue: pixel_in.in_blue};
  assign pixel_in.ready = can1;

  always_ff @(posedge clk) begin
    if (rst || cfg_hit || (emit && out_last)) begin
      p_col  <= '0;
      p_line <= '0;
      p_slot <= '0;
      pos    <= '0;
      done   <= 1'b0;
      ox     <= '0;
      oy     <= '0;
      o_slot <= '0;
    end else begin
      if (step) begin
        if (col_last) begin
          p_col  <= '0;
          p_line <= p_line + YW'(1);
          p_slot <= (p_slot == SW'(LINES - 1)) ? '0 : p_slot + SW'(1);
          if (is_pix && ((p_line + YW'(1)) == YW'(h_eff))) begin
            done <= 1'b1;
          end
        end else begin
          p_col <= p_col + CW'(1);
        end
        if (is_pix) begin
          pos <= pos + PW'(1);
        end
      end
      if (emit) begin
        if (out_col_last) begin
          ox     <= '0;
          oy     <= oy + RY'(1);
          o_slot <= (o_slot == SW'(LINES - 1)) ? '0 : o_slot + SW'(1);
        end else begin
          ox <= ox + CW'(1);
        end
      end
    end
  end

  // line banks, one per line slot
  rgb_t bank_q [LINES];

  for (genvar k = 0; k < LINES; k++) begin : g_bank
    mwf_line_bank #(.DEPTH(MAX_WIDTH), .AW(CW)) u_bank (
      .clk   (clk),
      .we    (step && is_pix && (p_slot == SW'(k))),
      .waddr (p_col),
      .wdata (in_pix),
      .re    (step),
      .raddr (direct ? ox : p_col),
      .rdata (bank_q[k])
    );
  end

  // stage 1: column gather
  logic          v1, e1, last1, int1, dir1;
  logic [CW-1:0] ox1;
  logic [RY-1:0] oy1;
  logic [SW-1:0] slot1;
  logic [SW-1:0] oslot1;
  rgb_t          pix1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (can1) begin
      v1 <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (can1) begin
      e1     <= emit;
      last1  <= out_last;
      int1   <= interior;
      dir1   <= direct;
      ox1    <= ox;
      oy1    <= oy;
      slot1  <= p_slot;
      oslot1 <= o_slot;
      pix1   <= in_pix;
    end
  end

  rgb_t rows [LINES];
  col_t col_new;

  // newest line comes straight from the item, older lines from the banks
  always_comb begin
    logic [SW-1:0] sidx;
    sidx    = '0;
    rows[0] = pix1;
    for (int k = 1; k < LINES; k++) begin
      if (int'(slot1) >= k) sidx = SW'(int'(slot1) - k);
      else sidx = SW'(int'(slot1) + LINES - k);
      rows[k] = bank_q[sidx];
    end
    col_new.colmax = rows[0];
    for (int k = 1; k < LINES; k++) begin
      if (k <= 2 * int'(r_eff)) col_new.colmax = rgb_max(col_new.colmax, rows[k]);
    end
    col_new.mid = dir1 ? bank_q[oslot1] : rows[SW'(r_eff)];
  end

  // stage 2: window cell chain
  logic          v2, e2, last2, int2, dir2;
  logic [CW-1:0] ox2;
  logic [RY-1:0] oy2;
  col_t          cell_q [LINES];

  assign can1 = !v1 || can2;
  assign can2 = !v2 || can3;
  assign can3 = !pixel_out.valid || pixel_out.ready;

  for (genvar j = 0; j < LINES; j++) begin : g_cell
    mwf_cell u_cell (
      .clk   (clk),
      .shift (can2 && v1),
      .d     ((j == 0) ? col_new : cell_q[(j == 0) ? 0 : j - 1]),
      .q     (cell_q[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (can2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (can2) begin
      e2    <= e1;
      last2 <= last1;
      int2  <= int1;
      dir2  <= dir1;
      ox2   <= ox1;
      oy2   <= oy1;
    end
  end

  // stage 3: maximum across the window columns, output register
  rgb_t win_max, result;

  always_comb begin
    win_max = cell_q[0].colmax;
    for (int j = 1; j < LINES; j++) begin
      if (j <= 2 * int'(r_eff)) win_max = rgb_max(win_max, cell_q[j].colmax);
    end
    if (int2) result = win_max;
    else if (dir2) result = cell_q[0].mid;
    else result = cell_q[SW'(r_eff)].mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_out.valid <= 1'b0;
    end else if (can3) begin
      pixel_out.valid <= v2 && e2;
    end
  end

  always_ff @(posedge clk) begin
    if (can3) begin
      pixel_out.out_x     <= 10'(ox2);
      pixel_out.out_y     <= 10'(oy2);
      pixel_out.out_red   <= result.red;
      pixel_out.out_green <= result.green;
      pixel_out.out_blue  <= result.blue;
      pixel_out.frame_end <= last2;
    end
  end

endmodule

// File: hw/rtl/mwf_line_bank.sv
`timescale 1ns / 1ps
// one line of pixel storage: one write port, one registered read port
// depends on mwf_pkg
module mwf_line_bank #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  mwf_pkg::rgb_t    wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output mwf_pkg::rgb_t    rdata
);
  import mwf_pkg::*;

  rgb_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/mwf_cell.sv
`timescale 1ns / 1ps
// window cell: holds one column summary, passes it to its neighbor on shift
// depends on mwf_pkg
module mwf_cell (
  input  logic          clk,
  input  logic          shift,
  input  mwf_pkg::col_t d,
  output mwf_pkg::col_t q
);
  import mwf_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// File: hw/rtl/mwf_checker.sv
`timescale 1ns / 1ps
// port checker for the rgb window maximum filter and its bind to the top level
// depends on rgb_window_maximum_filter port names
module mwf_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] out_x,
  input logic [9:0] out_y,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       frame_end
);

  logic       out_acc;
  logic       seen;
  logic       prev_end;
  logic [9:0] prev_x;

  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_acc) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_end <= frame_end;
      prev_x   <= out_x;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_x, out_y, out_red, out_green, out_blue, frame_end}))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    out_acc && seen && prev_end |-> out_x == 10'd0 && out_y == 10'd0)
    else $error("frame did not restart at origin");

  a_column_order: assert property (@(posedge clk) disable iff (rst)
    out_acc && seen && !prev_end |-> out_x == prev_x + 10'd1 || out_x == 10'd0)
    else $error("results out of raster order");

endmodule

bind rgb_window_maximum_filter mwf_checker u_mwf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (pixel_out.valid),
  .out_ready (pixel_out.ready),
  .out_x     (pixel_out.out_x),
  .out_y     (pixel_out.out_y),
  .out_red   (pixel_out.out_red),
  .out_green (pixel_out.out_green),
  .out_blue  (pixel_out.out_blue),
  .frame_end (pixel_out.frame_end)
);

// File: dv/rgb_window_maximum_filter_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of rgb_window_maximum_filter: random and directed frames
// depends on mwf_pkg, mwf_if and the rgb_window_maximum_filter rtl
module rgb_window_maximum_filter_tb;
  import mwf_pkg::*;

  localparam int LINE_SLOTS = 7;
  localparam int WMAX = 1024;
  localparam int HMAX = 1024;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    rgb_t       px;
    logic       fe;
  } result_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  mwf_in_if pin();
  mwf_out_if pout();

  rgb_window_maximum_filter DUT (
    .clk(clk), .rst(rst), .pixel_in(pin), .pixel_out(pout),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  rgb_t        pix_lines [LINE_SLOTS][WMAX];
  logic [10:0] cfg_width, cfg_height;
  logic [1:0]  cfg_radius;
  int          in_col, in_row, out_col, out_row;
  bit          frame_received;
  result_t     expected_q[$];

  int send_idle_pct, recv_idle_pct;
  int mismatches, items_sent, cycles;

  initial begin
    clk = 1'b0;
  end
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) pout.ready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic int width_eff();
    if (cfg_width == 0) return 1;
    return (cfg_width > WMAX) ? WMAX : int'(cfg_width);
  endfunction

  function automatic int height_eff();
    if (cfg_height == 0) return 1;
    return (cfg_height > HMAX) ? HMAX : int'(cfg_height);
  endfunction

  function automatic void restart_counts();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    frame_received = 0;
  endfunction

  // window maximum at the output position (own pixel at the border), then advance it
  function automatic void emit_window_max();
    int w, h, r;
    rgb_t m, v;
    bit last;
    result_t res;
    w = width_eff();
    h = height_eff();
    r = cfg_radius;
    m = pix_lines[out_row % LINE_SLOTS][out_col];
    if (out_col >= r && out_row >= r && out_col + r < w && out_row + r < h) begin
      for (int ly = out_row - r; ly <= out_row + r; ly++) begin
        for (int cx = out_col - r; cx <= out_col + r; cx++) begin
          v = pix_lines[ly % LINE_SLOTS][cx];
          if (v.red > m.red) m.red = v.red;
          if (v.green > m.green) m.green = v.green;
          if (v.blue > m.blue) m.blue = v.blue;
        end
      end
    end
    last = (out_col + 1 == w) && (out_row + 1 == h);
    res.x = out_col[9:0];
    res.y = out_row[9:0];
    res.px = m;
    res.fe = last;
    expected_q.push_back(res);
    if (last) begin
      restart_counts();
    end else if (out_col + 1 == w) begin
      out_col = 0;
      out_row = out_row + 1;
    end else begin
      out_col = out_col + 1;
    end
  endfunction

  function automatic void predict_item(logic cmd, rgb_t px);
    int w, h, r, pos;
    bit produce;
    w = width_eff();
    h = height_eff();
    r = cfg_radius;
    if (cmd == CMD_FLUSH) begin
      if (frame_received) emit_window_max();
      return;
    end
    if (frame_received) return;
    pix_lines[in_row % LINE_SLOTS][in_col] = px;
    pos = in_row * w + in_col;
    produce = pos >= r * w + r;
    if (in_col + 1 == w) begin
      in_col = 0;
      if (in_row + 1 == h) frame_received = 1;
      else in_row = in_row + 1;
    end else begin
      in_col = in_col + 1;
    end
    if (produce) emit_window_max();
  endfunction

  function automatic void report_mismatch(string what, result_t exp_r, result_t act_r);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected x=%0d y=%0d rgb=%h fe=%b, got x=%0d y=%0d rgb=%h fe=%b",
               what, exp_r.x, exp_r.y, exp_r.px, exp_r.fe,
               act_r.x, act_r.y, act_r.px, act_r.fe);
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (!rst && pout.valid && pout.ready) begin
      got.x = pout.out_x;
      got.y = pout.out_y;
      got.px = {pout.out_red, pout.out_green, pout.out_blue};
      got.fe = pout.frame_end;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.x !== want.x) report_mismatch("out_x", want, got);
        if (got.y !== want.y) report_mismatch("out_y", want, got);
        if (got.px.red !== want.px.red) report_mismatch("out_red", want, got);
        if (got.px.green !== want.px.green) report_mismatch("out_green", want, got);
        if (got.px.blue !== want.px.blue) report_mismatch("out_blue", want, got);
        if (got.fe !== want.fe) report_mismatch("frame_end", want, got);
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_item(logic cmd, rgb_t px);
    if ($urandom_range(99) < send_idle_pct) begin
      pin.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    pin.valid <= 1'b1;
    pin.command <= cmd;
    pin.in_red <= px.red;
    pin.in_green <= px.green;
    pin.in_blue <= px.blue;
    @(posedge clk);
    while (!pin.ready) @(posedge clk);
    predict_item(cmd, px);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    pin.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    wait_drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIDTH: begin
        cfg_width = value[10:0];
        restart_counts();
      end
      REG_HEIGHT: begin
        cfg_height = value[10:0];
        restart_counts();
      end
      REG_RADIUS: begin
        cfg_radius = value[1:0];
        restart_counts();
      end
      default: ;
    endcase
  endtask

  task automatic set_frame(int w, int h, int r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, r);
  endtask

  function automatic rgb_t random_pixel();
    rgb_t p;
    p = rgb_t'($urandom());
    if ($urandom_range(9) == 0) p.red = 8'hff;
    if ($urandom_range(9) == 0) p.green = 8'h00;
    return p;
  endfunction

  // one frame of pixels, optionally with stray flushes and dropped pixels, then drain
  task automatic run_frame(int npix, bit noisy);
    for (int i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(99) < 4) send_item(CMD_FLUSH, random_pixel());
      send_item(CMD_PIXEL, random_pixel());
    end
    while (frame_received) begin
      if (noisy && $urandom_range(99) < 5) send_item(CMD_PIXEL, random_pixel());
      send_item(CMD_FLUSH, random_pixel());
    end
  endtask

  task automatic test_directed_small();
    rgb_t px;
    set_frame(3, 3, 1);
    send_item(CMD_FLUSH, 24'hffffff);        // flush before the frame is in
    send_item(CMD_PIXEL, 24'h000000);
    send_item(CMD_PIXEL, 24'hff0000);
    send_item(CMD_PIXEL, 24'h00ff00);
    send_item(CMD_PIXEL, 24'h0000ff);
    send_item(CMD_PIXEL, 24'h010203);
    wait_drain();                            // sender holds off until results are in
    send_item(CMD_PIXEL, 24'h7f807f);
    send_item(CMD_PIXEL, 24'h808080);
    send_item(CMD_PIXEL, 24'hffffff);
    send_item(CMD_PIXEL, 24'h55aa55);
    send_item(CMD_PIXEL, 24'h123456);        // dropped while draining
    while (frame_received) send_item(CMD_FLUSH, 24'h0);
    write_reg(reg_idx_t'(2'd3), 32'hffffffff);  // unknown register, ignored
    set_frame(2, 1, 0);
    px = 24'habcdef;
    send_item(CMD_PIXEL, px);
    send_item(CMD_PIXEL, ~px);
  endtask

  task automatic test_size_extremes();
    set_frame(1024, 3, 1);
    run_frame(40, 0);                        // partial frames, restarted by the next write
    set_frame(2047, 1, 0);
    run_frame(30, 0);
    set_frame(1, 1024, 1);
    run_frame(30, 0);
    set_frame(0, 2047, 3);
    run_frame(20, 0);
    set_frame(0, 0, 2);
    run_frame(1, 1);
    set_frame(5, 4, 3);
    run_frame(20, 1);
  endtask

  task automatic test_random_frames(int budget);
    int target, w, h;
    target = items_sent + budget;
    while (items_sent < target) begin
      w = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      set_frame(w, h, $urandom_range(3));
      if ($urandom_range(9) == 0) run_frame($urandom_range(1, w * h), 1);
      else run_frame(w * h, $urandom_range(1));
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pin.valid = 1'b0;
    pin.command = CMD_PIXEL;
    pin.in_red = '0;
    pin.in_green = '0;
    pin.in_blue = '0;
    pout.ready = 1'b0;
    mismatches = 0;
    items_sent = 0;
    cycles = 0;
    cfg_width = WIDTH_RST;
    cfg_height = HEIGHT_RST;
    cfg_radius = RADIUS_RST;
    foreach (pix_lines[i, j]) pix_lines[i][j] = '0;
    restart_counts();
    send_idle_pct = 30;
    recv_idle_pct = 72;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_small();
    test_size_extremes();
    test_random_frames(240);
    send_idle_pct = 72;
    recv_idle_pct = 30;
    test_random_frames(240);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(240);

    wait_drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: rgb_window_maximum_filter.f
hw/rtl/mwf_pkg.sv
hw/rtl/mwf_if.sv
hw/rtl/mwf_line_bank.sv
hw/rtl/mwf_cell.sv
hw/rtl/rgb_window_maximum_filter.sv
hw/rtl/mwf_checker.sv
dv/rgb_window_maximum_filter_tb.sv
